// ----- src/knq_pkg.sv -----
package knq_pkg;

   localparam int MAX_POINTS_DEF = 64;
   localparam int MAX_K_DEF      = 16;
   localparam int COORD_W        = 24;
   localparam int DIST_W         = 52;
   localparam int OUT_IDX_W      = 6;
   localparam int NC_W           = 5;
   localparam int NC_RESET       = 10;
   localparam int DIST_LAT       = 4;

   typedef enum logic [1:0] {
      FN_LOAD  = 2'd0,
      FN_CLEAR = 2'd1,
      FN_QUERY = 2'd2,
      FN_NONE  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   localparam logic [0:0] REG_NEIGHBOR_COUNT = 1'b0;

   typedef struct packed {
      logic [1:0]                func;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic signed [COORD_W-1:0] coord_z;
   } req_type;

   typedef struct packed {
      logic [OUT_IDX_W-1:0] point_index;
      logic [DIST_W-1:0]    distance_squared;
      logic                 valid_res;
      logic                 last;
   } rsp_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
   } point_type;

   typedef struct packed {
      logic clr;
      logic pop;
      logic unsorted;
   } ctl_type;

endpackage

// ----- src/knq_dist.sv -----
module knq_dist
   import knq_pkg::*;
#(
   parameter int IDX_W = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_vld,
   input  logic [IDX_W-1:0]  in_idx,
   input  point_type         pt,
   input  point_type         qry,
   output logic              out_vld,
   output logic [DIST_W-1:0] out_dist,
   output logic [IDX_W-1:0]  out_idx
);

   logic [COORD_W-1:0]   ax_in, ay_in, az_in;
   logic [COORD_W-1:0]   ax_ff, ay_ff, az_ff;
   logic [2*COORD_W-1:0] sx_ff, sy_ff, sz_ff;
   logic [DIST_W-1:0]    sum_ff;
   logic [2:0]           vld_ff;
   logic [IDX_W-1:0]     idx_a_ff, idx_b_ff, idx_c_ff;

   function automatic logic [COORD_W-1:0] abs_diff(logic [COORD_W-1:0] a,
                                                   logic [COORD_W-1:0] b);
      logic [COORD_W:0] d;
      logic [COORD_W:0] m;
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      m = d[COORD_W] ? (~d + 1'b1) : d;
      return m[COORD_W-1:0];
   endfunction

   always_comb begin
      ax_in = abs_diff(pt.x, qry.x);
      ay_in = abs_diff(pt.y, qry.y);
      az_in = abs_diff(pt.z, qry.z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[1:0], in_vld};
      end
      ax_ff    <= ax_in;
      ay_ff    <= ay_in;
      az_ff    <= az_in;
      idx_a_ff <= in_idx;
      sx_ff    <= ax_ff * ax_ff;
      sy_ff    <= ay_ff * ay_ff;
      sz_ff    <= az_ff * az_ff;
      idx_b_ff <= idx_a_ff;
      sum_ff   <= DIST_W'(sx_ff) + DIST_W'(sy_ff) + DIST_W'(sz_ff);
      idx_c_ff <= idx_b_ff;
   end

   assign out_vld  = vld_ff[2];
   assign out_dist = sum_ff;
   assign out_idx  = idx_c_ff;

endmodule

// ----- src/knq_cell.sv -----
module knq_cell
   import knq_pkg::*;
#(
   parameter int IDX_W = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  ctl_type           ctl,
   input  logic              in_vld,
   input  logic [DIST_W-1:0] in_dist,
   input  logic [IDX_W-1:0]  in_idx,
   input  logic              nbr_vld,
   input  logic [DIST_W-1:0] nbr_dist,
   input  logic [IDX_W-1:0]  nbr_idx,
   output logic              pass_vld,
   output logic [DIST_W-1:0] pass_dist,
   output logic [IDX_W-1:0]  pass_idx,
   output logic              held_vld,
   output logic [DIST_W-1:0] held_dist,
   output logic [IDX_W-1:0]  held_idx
);

   logic              hv_ff, hv_in, pv_ff, pv_in;
   logic [DIST_W-1:0] hd_ff, hd_in, pd_ff, pd_in;
   logic [IDX_W-1:0]  hi_ff, hi_in, pi_ff, pi_in;

   // An empty cell takes the item. When sorted, an item that orders before the held
   // one, by distance then index, displaces it and the held one moves on; else the new one moves on.
   always_comb begin
      hv_in = hv_ff;
      hd_in = hd_ff;
      hi_in = hi_ff;
      pv_in = 1'b0;
      pd_in = in_dist;
      pi_in = in_idx;
      if (ctl.clr) begin
         hv_in = 1'b0;
      end else if (ctl.pop) begin
         hv_in = nbr_vld;
         hd_in = nbr_dist;
         hi_in = nbr_idx;
      end else if (in_vld) begin
         if (!hv_ff) begin
            hv_in = 1'b1;
            hd_in = in_dist;
            hi_in = in_idx;
         end else if (!ctl.unsorted && ((in_dist < hd_ff) ||
                                        ((in_dist == hd_ff) && (in_idx < hi_ff)))) begin
            hd_in = in_dist;
            hi_in = in_idx;
            pv_in = 1'b1;
            pd_in = hd_ff;
            pi_in = hi_ff;
         end else begin
            pv_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hv_ff <= 1'b0;
         pv_ff <= 1'b0;
      end else begin
         hv_ff <= hv_in;
         pv_ff <= pv_in;
      end
      hd_ff <= hd_in;
      hi_ff <= hi_in;
      pd_ff <= pd_in;
      pi_ff <= pi_in;
   end

   assign pass_vld  = pv_ff;
   assign pass_dist = pd_ff;
   assign pass_idx  = pi_ff;
   assign held_vld  = hv_ff;
   assign held_dist = hd_ff;
   assign held_idx  = hi_ff;

endmodule

// ----- src/k_nearest_point_query.sv -----
// Channel  Direction  Handshake                     Payload
// req      in         req_valid / req_stall         req_type
// rsp      out        rsp_valid / rsp_stall         rsp_type
// csr      in         csr_psel/penable/pready APB   neighbor_count
//
// A query scans the stored points (one memory read per cycle), lets the
// sorting cell chain settle, then emits its results, which the result side
// may stall.
// An empty table skips straight to its single result.
// Reset is synchronous and empties the table; req_stall is high while a query runs.
module k_nearest_point_query
   import knq_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int MAX_K      = MAX_K_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int IDX_W   = $clog2(MAX_POINTS);
   localparam int CNT_W   = $clog2(MAX_POINTS + 1);
   localparam int KW      = $clog2(MAX_K + 1);
   localparam int DRAIN   = MAX_K + DIST_LAT + 2;
   localparam int DRAIN_W = $clog2(DRAIN + 1);

   point_type         mem [MAX_POINTS];
   point_type         rd_ff, qry_ff;
   logic              rd_vld_ff;
   logic [IDX_W-1:0]  rd_idx_ff;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  scan_ff;
   logic [DRAIN_W-1:0] drain_ff;
   logic [KW-1:0]     remain_ff, n_emit;
   logic              unsorted_ff, empty_ff, unsorted_now;
   logic [NC_W-1:0]   nc_ff;
   logic [KW-1:0]     k_eff;

   logic req_acc, rsp_acc, q_acc, csr_wr;
   logic scan_done, drain_done, emit_done;

   logic              dv;
   logic [DIST_W-1:0] dd;
   logic [IDX_W-1:0]  di;
   ctl_type           ctl;

   logic              c_in_v [MAX_K+1];
   logic [DIST_W-1:0] c_in_d [MAX_K+1];
   logic [IDX_W-1:0]  c_in_i [MAX_K+1];
   logic              h_v [MAX_K+1];
   logic [DIST_W-1:0] h_d [MAX_K+1];
   logic [IDX_W-1:0]  h_i [MAX_K+1];

   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid && !rsp_stall;
   assign q_acc   = req_acc && (req_data.func == FN_QUERY);
   assign csr_wr  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      if (nc_ff == '0) begin
         k_eff = KW'(1);
      end else if (32'(nc_ff) > MAX_K) begin
         k_eff = KW'(MAX_K);
      end else begin
         k_eff = KW'(nc_ff);
      end
      unsorted_now = (32'(count_ff) <= 32'(k_eff));
      if (count_ff == '0) begin
         n_emit = KW'(1);
      end else if (unsorted_now) begin
         n_emit = KW'(count_ff);
      end else begin
         n_emit = k_eff;
      end
   end

   assign scan_done  = (scan_ff == count_ff - 1'b1);
   assign drain_done = (drain_ff == DRAIN_W'(DRAIN));
   assign emit_done  = rsp_acc && (remain_ff == KW'(1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_acc) begin
               state_in = (count_ff == '0) ? ST_EMIT : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (drain_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_stall = 1'b0;
         ST_SCAN:  req_stall = 1'b1;
         ST_DRAIN: req_stall = 1'b1;
         ST_EMIT:  rsp_valid = 1'b1;
         default:  req_stall = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         nc_ff     <= NC_W'(NC_RESET);
         rd_vld_ff <= 1'b0;
         scan_ff   <= '0;
         drain_ff  <= '0;
         remain_ff <= '0;
         empty_ff  <= 1'b0;
         unsorted_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= (state_ff == ST_SCAN);
         if (csr_wr && (csr_paddr[2] == REG_NEIGHBOR_COUNT)) begin
            nc_ff <= csr_pwdata[NC_W-1:0];
         end
         if (req_acc && (req_data.func == FN_LOAD) && (32'(count_ff) < MAX_POINTS)) begin
            count_ff <= count_ff + 1'b1;
         end else if (req_acc && (req_data.func == FN_CLEAR)) begin
            count_ff <= '0;
         end
         if (q_acc) begin
            scan_ff     <= '0;
            drain_ff    <= '0;
            remain_ff   <= n_emit;
            empty_ff    <= (count_ff == '0);
            unsorted_ff <= unsorted_now;
         end else begin
            if (state_ff == ST_SCAN) begin
               scan_ff <= scan_ff + 1'b1;
            end
            if (state_ff == ST_DRAIN) begin
               drain_ff <= drain_ff + 1'b1;
            end
            if (rsp_acc) begin
               remain_ff <= remain_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc && (req_data.func == FN_LOAD) && (32'(count_ff) < MAX_POINTS)) begin
         mem[count_ff[IDX_W-1:0]] <= '{x: req_data.coord_x, y: req_data.coord_y,
                                       z: req_data.coord_z};
      end
      rd_ff     <= mem[scan_ff[IDX_W-1:0]];
      rd_idx_ff <= scan_ff[IDX_W-1:0];
      if (q_acc) begin
         qry_ff <= '{x: req_data.coord_x, y: req_data.coord_y, z: req_data.coord_z};
      end
   end

   knq_dist #(.IDX_W(IDX_W)) u_dist (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (rd_vld_ff),
      .in_idx   (rd_idx_ff),
      .pt       (rd_ff),
      .qry      (qry_ff),
      .out_vld  (dv),
      .out_dist (dd),
      .out_idx  (di)
   );

   assign ctl.clr      = q_acc;
   assign ctl.pop      = rsp_acc;
   assign ctl.unsorted = unsorted_ff;

   assign c_in_v[0] = dv;
   assign c_in_d[0] = dd;
   assign c_in_i[0] = di;
   assign h_v[MAX_K] = 1'b0;
   assign h_d[MAX_K] = '0;
   assign h_i[MAX_K] = '0;

   for (genvar g = 0; g < MAX_K; g++) begin : g_cell
      knq_cell #(.IDX_W(IDX_W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .in_vld    (c_in_v[g]),
         .in_dist   (c_in_d[g]),
         .in_idx    (c_in_i[g]),
         .nbr_vld   (h_v[g+1]),
         .nbr_dist  (h_d[g+1]),
         .nbr_idx   (h_i[g+1]),
         .pass_vld  (c_in_v[g+1]),
         .pass_dist (c_in_d[g+1]),
         .pass_idx  (c_in_i[g+1]),
         .held_vld  (h_v[g]),
         .held_dist (h_d[g]),
         .held_idx  (h_i[g])
      );
   end

   always_comb begin
      rsp_data.valid_res        = !empty_ff;
      rsp_data.last             = (remain_ff == KW'(1));
      rsp_data.point_index      = empty_ff ? '0 : OUT_IDX_W'(h_i[0]);
      rsp_data.distance_squared = empty_ff ? '0 : h_d[0];
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_NEIGHBOR_COUNT) ? 32'(nc_ff) : '0;

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.valid_res |-> rsp_data.last)
      else $error("empty-table result not marked last");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= MAX_POINTS)
      else $error("point count above table size");

   a_query_start: assert property (@(posedge clock) disable iff (reset)
      q_acc && (count_ff != '0) |=> state_ff == ST_SCAN)
      else $error("query on a filled table did not start a scan");

   a_emit_cell: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.valid_res |-> h_v[0])
      else $error("result taken from an empty cell");

endmodule

// ----- tb/sv/k_nearest_point_query_tb.sv -----
module k_nearest_point_query_tb;
   import knq_pkg::*;

   localparam int TABLE_DEPTH = MAX_POINTS_DEF;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [2:0] NC_ADDR = 3'(REG_NEIGHBOR_COUNT) << 2;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   k_nearest_point_query i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Shadow of the block's state.
   logic signed [COORD_W-1:0] tab_x [TABLE_DEPTH];
   logic signed [COORD_W-1:0] tab_y [TABLE_DEPTH];
   logic signed [COORD_W-1:0] tab_z [TABLE_DEPTH];
   int          stored_points = 0;
   logic [NC_W-1:0] k_setting = NC_W'(NC_RESET);

   req_type pending_items[$];
   rsp_type neighbor_results[$];
   int      errors = 0;
   int      queries_seen = 0;
   int      results_seen = 0;
   int      idle_cycles = 0;
   bit      quiet_phase = 1'b0;
   bit      timed_out = 1'b0;

   task automatic add_pending(req_type it);
      pending_items.insert(pending_items.size(), it);
   endtask

   task automatic add_expected(rsp_type r);
      neighbor_results.insert(neighbor_results.size(), r);
   endtask

   function automatic logic [DIST_W-1:0] sq_dist(int idx, req_type q);
      longint dx, dy, dz;
      dx = longint'(tab_x[idx]) - longint'(q.coord_x);
      dy = longint'(tab_y[idx]) - longint'(q.coord_y);
      dz = longint'(tab_z[idx]) - longint'(q.coord_z);
      return DIST_W'(dx * dx + dy * dy + dz * dz);
   endfunction

   task automatic predict_item(req_type it);
      int k;
      rsp_type r;
      logic [DIST_W-1:0] d, best_d, prev_d;
      int best_i, prev_i;
      bit found;
      case (it.func)
         FN_LOAD: begin
            if (stored_points < TABLE_DEPTH) begin
               tab_x[stored_points] = it.coord_x;
               tab_y[stored_points] = it.coord_y;
               tab_z[stored_points] = it.coord_z;
               stored_points++;
            end
         end
         FN_CLEAR: stored_points = 0;
         FN_QUERY: begin
            queries_seen++;
            if (stored_points == 0) begin
               r = '0;
               r.last = 1'b1;
               add_expected(r);
            end else begin
               k = (k_setting == 0) ? 1 : int'(k_setting);
               if (k > MAX_K_DEF) k = MAX_K_DEF;
               if (stored_points <= k) begin
                  for (int i = 0; i < stored_points; i++) begin
                     r.point_index = OUT_IDX_W'(i);
                     r.distance_squared = sq_dist(i, it);
                     r.valid_res = 1'b1;
                     r.last = (i + 1 == stored_points);
                     add_expected(r);
                  end
               end else begin
                  prev_d = '0;
                  prev_i = -1;
                  for (int n = 0; n < k; n++) begin
                     found = 1'b0;
                     best_d = '0;
                     best_i = 0;
                     for (int i = 0; i < stored_points; i++) begin
                        d = sq_dist(i, it);
                        if (n > 0 && (d < prev_d || (d == prev_d && i <= prev_i)))
                           continue;
                        if (!found || d < best_d) begin
                           found = 1'b1;
                           best_d = d;
                           best_i = i;
                        end
                     end
                     r.point_index = OUT_IDX_W'(best_i);
                     r.distance_squared = best_d;
                     r.valid_res = 1'b1;
                     r.last = (n + 1 == k);
                     add_expected(r);
                     prev_d = best_d;
                     prev_i = best_i;
                  end
               end
            end
         end
         default: ;
      endcase
   endtask

   // Driver: pops items from the pending queue with random bursts of idling.
   int req_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_item(req_data);
         end
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0 &&
                         !(quiet_phase == 1'b0 && $urandom_range(0, 9) == 0)) begin
               req_data <= pending_items.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
               if (!quiet_phase && pending_items.size() > 0)
                  req_gap <= $urandom_range(0, 17);
            end
         end
      end
   end

   // Monitor and result-side stalling.
   int rsp_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (neighbor_results.size() == 0) begin
               errors++;
               $display("%0t: unexpected result %p", $time, rsp_data);
            end else begin
               rsp_type e;
               e = neighbor_results.pop_front();
               if (e.point_index !== rsp_data.point_index) begin
                  errors++;
                  $display("%0t: point_index expected %0d actual %0d", $time,
                           e.point_index, rsp_data.point_index);
               end
               if (e.distance_squared !== rsp_data.distance_squared) begin
                  errors++;
                  $display("%0t: distance_squared expected %0d actual %0d", $time,
                           e.distance_squared, rsp_data.distance_squared);
               end
               if (e.valid_res !== rsp_data.valid_res) begin
                  errors++;
                  $display("%0t: valid_res expected %0b actual %0b", $time,
                           e.valid_res, rsp_data.valid_res);
               end
               if (e.last !== rsp_data.last) begin
                  errors++;
                  $display("%0t: last expected %0b actual %0b", $time,
                           e.last, rsp_data.last);
               end
            end
         end
         if (quiet_phase) begin
            rsp_stall <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(0, 11) == 0) begin
            rsp_gap <= $urandom_range(0, 17);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog on cycles without any accepted item or CSR selection.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
         timed_out <= 1'b1;
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic csr_write(logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= NC_ADDR;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      k_setting = NC_W'(value);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_items.size() > 0 || req_valid || neighbor_results.size() > 0)
         @(posedge clock);
      // Loads and clears leave nothing to wait for, so give the block time to settle.
      repeat (MAX_POINTS_DEF + MAX_K_DEF + 20) @(posedge clock);
   endtask

   function automatic req_type make_item(func_type f, logic [23:0] x, logic [23:0] y,
                                         logic [23:0] z);
      req_type it;
      it.func = f;
      it.coord_x = x;
      it.coord_y = y;
      it.coord_z = z;
      return it;
   endfunction

   function automatic logic [23:0] rand_coord(bit narrow);
      if (narrow) return 24'($signed($urandom_range(0, 64)) - 32);
      return 24'($urandom);
   endfunction

   task automatic queue_random_set(int loads, int queries, bit narrow);
      add_pending(make_item(FN_CLEAR, rand_coord(0), rand_coord(0), rand_coord(0)));
      for (int i = 0; i < loads; i++)
         add_pending(make_item(FN_LOAD, rand_coord(narrow), rand_coord(narrow),
                               rand_coord(narrow)));
      for (int i = 0; i < queries; i++) begin
         if ($urandom_range(0, 9) == 0)
            add_pending(make_item(FN_NONE, rand_coord(0), rand_coord(0), rand_coord(0)));
         add_pending(make_item(FN_QUERY, rand_coord(narrow), rand_coord(narrow),
                               rand_coord(narrow)));
      end
   endtask

   initial begin
      int n_sent;
      int loads;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty table, extremes, unused code, duplicates for tie ordering.
      add_pending(make_item(FN_QUERY, 24'h800000, 24'h7FFFFF, 24'h0));
      add_pending(make_item(FN_LOAD, 24'h800000, 24'h800000, 24'h800000));
      add_pending(make_item(FN_QUERY, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF));
      add_pending(make_item(FN_NONE, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
      for (int i = 0; i < 12; i++)
         add_pending(make_item(FN_LOAD, 24'(i % 3), 24'h0, 24'h0));
      add_pending(make_item(FN_QUERY, 24'h0, 24'h0, 24'h0));
      add_pending(make_item(FN_QUERY, 24'h7FFFFF, 24'h800000, 24'h7FFFFF));
      add_pending(make_item(FN_CLEAR, 24'h0, 24'h0, 24'h0));
      add_pending(make_item(FN_QUERY, 24'h1, 24'h2, 24'h3));
      wait_idle();

      // Fill the table past capacity so the overflowing loads are dropped.
      csr_write(32'd16);
      queue_random_set(TABLE_DEPTH + 3, 3, 1'b0);
      wait_idle();
      csr_write(32'd0);
      add_pending(make_item(FN_QUERY, 24'h0, 24'h0, 24'h0));
      wait_idle();
      csr_write(32'd31);
      add_pending(make_item(FN_QUERY, 24'h123456, 24'h0, 24'h0));
      wait_idle();

      // Roughly 90 items went out above; the random sets bring the total near 270.
      n_sent = 0;
      while (n_sent < 180) begin
         csr_write($urandom_range(1, 16));
         loads = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 24);
         queue_random_set(loads, 4, $urandom_range(0, 1));
         n_sent += loads + 5;
         if (n_sent >= 130) quiet_phase = 1'b1;
         wait_idle();
      end

      $display("Covered %0d queries with %0d neighbor results checked.",
               queries_seen, results_seen);
      $display("Settings of neighbor_count from zero to 31, with stalls on both sides.");
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
